@@ rtl/resource_pool_allocator_idle_reclaim_top_assert.svh @@
// Assertion macros shared by the checker of the slot pool allocator.
// No dependencies.
`ifndef RESOURCE_POOL_ALLOCATOR_IDLE_RECLAIM_TOP_ASSERT_SVH
`define RESOURCE_POOL_ALLOCATOR_IDLE_RECLAIM_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define RPA_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define RPA_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/rpa_pkg.sv @@
// Package for the slot pool allocator: sizes, request and status codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package rpa_pkg;
    localparam int POOL_SLOTS   = 16;
    localparam int MAX_SESSIONS = 64;
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

    localparam logic [2:0] REQ_OPEN    = 3'd0;
    localparam logic [2:0] REQ_ACQUIRE = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_DESTROY = 3'd3;
    localparam logic [2:0] REQ_RECLAIM = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_UNBOUND   = 2'd3;

    // classified request handed from front to back
    typedef struct packed {
        logic        valid_type;
        logic [2:0]  req_type;
        logic [5:0]  session_num;
        logic [63:0] now_time;
    } req_t;
endpackage

@@ rtl/rpa_req_queue.sv @@
// Short request queue between the front and the back of the allocator.
// Depends on rpa_pkg.
`timescale 1ns / 1ps
module rpa_req_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  rpa_pkg::req_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output rpa_pkg::req_t  rd_data
);
    rpa_pkg::req_t q_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) begin
            q_reg[wp_reg] <= wr_data;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
        end
    end
endmodule

@@ rtl/rpa_front.sv @@
// Front end: accepts requests, flags unknown request types, feeds the queue.
// Depends on rpa_pkg.
`timescale 1ns / 1ps
module rpa_front (
    input  logic [2:0]    req_type,
    input  logic [5:0]    session_num,
    input  logic [63:0]   now_time,
    output rpa_pkg::req_t req
);
    always_comb begin
        req.req_type    = req_type;
        req.session_num = session_num;
        req.now_time    = now_time;
        req.valid_type  = (req_type inside {rpa_pkg::REQ_OPEN, rpa_pkg::REQ_ACQUIRE,
                           rpa_pkg::REQ_RELEASE, rpa_pkg::REQ_DESTROY,
                           rpa_pkg::REQ_RECLAIM});
    end
endmodule

@@ rtl/rpa_back.sv @@
// Back end: pool state, session table memory with clearing pass, and a sequencer that
// runs one request, reading the table for each slot, then checking it. Depends on rpa_pkg.
`timescale 1ns / 1ps
module rpa_back #(
    parameter int POOL_SLOTS   = rpa_pkg::POOL_SLOTS,
    parameter int MAX_SESSIONS = rpa_pkg::MAX_SESSIONS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [31:0]   idle_timeout,
    input  logic          req_valid,
    output logic          req_ready,
    input  rpa_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [1:0]    res_status,
    output logic          res_slot_valid,
    output logic [3:0]    res_slot_num,
    output logic [4:0]    res_reclaimed
);
    localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int AW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_LOOK, S_EXEC, S_OUT
    } state_t;
    state_t state_reg;

    // one session table entry
    typedef struct packed {
        logic          exists;
        logic          bound_v;
        logic [SW-1:0] slot;
    } sess_t;

    logic [SW-1:0] free_list_reg [POOL_SLOTS];
    logic [SW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic          own_v_reg [POOL_SLOTS];
    logic [5:0]    own_reg   [POOL_SLOTS];
    logic [63:0]   stamp_reg [POOL_SLOTS];

    sess_t         sess_mem [MAX_SESSIONS];
    sess_t         sess_rd_reg;
    logic          sess_we;
    logic [AW-1:0] sess_waddr;
    sess_t         sess_wdata;
    logic [AW-1:0] sess_raddr;
    logic [AW-1:0] clr_reg;

    rpa_pkg::req_t cur_reg;
    logic [SW-1:0] scan_reg;
    logic [4:0]    rec_reg;
    logic [1:0]    status_reg;
    logic          sv_reg;
    logic [3:0]    snum_reg;
    logic [63:0]   age;
    logic          known;
    logic          s_in_range;
    logic [5:0]    s;
    logic [31:0]   tail_sum;
    logic [SW-1:0] tail;
    logic [SW-1:0] head_next;
    logic [SW-1:0] head_slot;
    logic [5:0]    scan_owner;
    logic          trig;
    logic          owner_live;

    assign s          = cur_reg.session_num;
    assign s_in_range = (32'(s) < MAX_SESSIONS);
    assign known      = s_in_range && sess_rd_reg.exists;
    assign tail_sum   = 32'(head_reg) + 32'(count_reg);
    assign tail       = SW'((tail_sum >= POOL_SLOTS) ? tail_sum - POOL_SLOTS : tail_sum);
    assign head_next  = (32'(head_reg) == POOL_SLOTS - 1) ? '0 : head_reg + SW'(1);
    assign head_slot  = free_list_reg[head_reg];
    assign age        = cur_reg.now_time - stamp_reg[scan_reg];
    assign scan_owner = own_reg[scan_reg];
    assign trig       = own_v_reg[scan_reg] && (age > {32'd0, idle_timeout});
    // table data in S_SCAN_CHK belongs to the owner of the slot under scan
    assign owner_live = (32'(scan_owner) < MAX_SESSIONS) && sess_rd_reg.exists
                        && sess_rd_reg.bound_v;

    assign req_ready      = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_OUT);
    assign res_status     = status_reg;
    assign res_slot_valid = sv_reg;
    assign res_slot_num   = snum_reg;
    assign res_reclaimed  = rec_reg;

    // session table read address: data arrives the cycle after
    always_comb begin
        case (state_reg)
            S_IDLE:    sess_raddr = AW'(req.session_num);
            S_SCAN_RD: sess_raddr = AW'(scan_owner);
            default:   sess_raddr = AW'(s);
        endcase
    end

    // session table write port
    always_comb begin
        sess_we    = 1'b0;
        sess_waddr = AW'(s);
        sess_wdata = '0;
        case (state_reg)
            S_CLEAR: begin
                sess_we    = 1'b1;
                sess_waddr = clr_reg;
            end
            S_SCAN_CHK: begin
                if (trig && owner_live) begin
                    sess_we           = 1'b1;
                    sess_waddr        = AW'(scan_owner);
                    sess_wdata.exists = 1'b1;
                end
            end
            S_EXEC: begin
                case (cur_reg.req_type)
                    rpa_pkg::REQ_OPEN: begin
                        if (s_in_range && !sess_rd_reg.exists) begin
                            sess_we           = 1'b1;
                            sess_wdata.exists = 1'b1;
                        end
                    end
                    rpa_pkg::REQ_ACQUIRE: begin
                        if (count_reg != '0 && known) begin
                            sess_we            = 1'b1;
                            sess_wdata.exists  = 1'b1;
                            sess_wdata.bound_v = 1'b1;
                            sess_wdata.slot    = head_slot;
                        end
                    end
                    rpa_pkg::REQ_RELEASE: begin
                        if (known && sess_rd_reg.bound_v) begin
                            sess_we           = 1'b1;
                            sess_wdata.exists = 1'b1;
                        end
                    end
                    rpa_pkg::REQ_DESTROY: begin
                        if (known) sess_we = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sess_we) sess_mem[sess_waddr] <= sess_wdata;
        sess_rd_reg <= sess_mem[sess_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            head_reg  <= '0;
            count_reg <= CW'(POOL_SLOTS);
            for (int i = 0; i < POOL_SLOTS; i++) begin
                free_list_reg[i] <= SW'(i);
                own_v_reg[i]     <= 1'b0;
                own_reg[i]       <= '0;
                stamp_reg[i]     <= '0;
            end
            scan_reg <= '0;
            rec_reg  <= '0;
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == MAX_SESSIONS - 1) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (req_valid) begin
                        cur_reg    <= req;
                        scan_reg   <= '0;
                        rec_reg    <= '0;
                        status_reg <= rpa_pkg::ST_OK;
                        sv_reg     <= 1'b0;
                        snum_reg   <= '0;
                        if (req.valid_type && (req.req_type == rpa_pkg::REQ_RECLAIM ||
                            (req.req_type == rpa_pkg::REQ_ACQUIRE && count_reg == '0)))
                            state_reg <= S_SCAN_RD;
                        else if (req.valid_type)
                            state_reg <= S_EXEC;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    // a trigger counts a reclaim and releases the owner's current slot if the owner is bound
                    if (trig) begin
                        if (rec_reg != 5'd31) rec_reg <= rec_reg + 5'd1;
                        if (owner_live) begin
                            own_v_reg[sess_rd_reg.slot] <= 1'b0;
                            own_reg[sess_rd_reg.slot]   <= '0;
                            stamp_reg[sess_rd_reg.slot] <= '0;
                            if (count_reg < CW'(POOL_SLOTS)) begin
                                free_list_reg[tail] <= sess_rd_reg.slot;
                                count_reg <= count_reg + CW'(1);
                            end
                        end
                    end
                    if (32'(scan_reg) == POOL_SLOTS - 1) begin
                        state_reg <= (cur_reg.req_type == rpa_pkg::REQ_ACQUIRE) ? S_LOOK : S_OUT;
                    end else begin
                        scan_reg  <= scan_reg + SW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_LOOK: begin
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_OUT;
                    case (cur_reg.req_type)
                        rpa_pkg::REQ_ACQUIRE: begin
                            if (count_reg == '0) begin
                                status_reg <= rpa_pkg::ST_EXHAUSTED;
                            end else if (!known) begin
                                // pop then push back: list rotates by one
                                status_reg <= rpa_pkg::ST_NOT_FOUND;
                                head_reg <= head_next;
                                free_list_reg[tail] <= head_slot;
                            end else begin
                                head_reg  <= head_next;
                                count_reg <= count_reg - CW'(1);
                                own_v_reg[head_slot] <= 1'b1;
                                own_reg[head_slot]   <= s;
                                stamp_reg[head_slot] <= cur_reg.now_time;
                                sv_reg   <= 1'b1;
                                snum_reg <= 4'(head_slot);
                            end
                        end
                        rpa_pkg::REQ_RELEASE, rpa_pkg::REQ_DESTROY: begin
                            if (!known) begin
                                status_reg <= rpa_pkg::ST_NOT_FOUND;
                            end else if (!sess_rd_reg.bound_v &&
                                         cur_reg.req_type == rpa_pkg::REQ_RELEASE) begin
                                status_reg <= rpa_pkg::ST_UNBOUND;
                            end else if (sess_rd_reg.bound_v) begin
                                own_v_reg[sess_rd_reg.slot] <= 1'b0;
                                own_reg[sess_rd_reg.slot]   <= '0;
                                stamp_reg[sess_rd_reg.slot] <= '0;
                                if (count_reg < CW'(POOL_SLOTS)) begin
                                    free_list_reg[tail] <= sess_rd_reg.slot;
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_OUT: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/resource_pool_allocator_idle_reclaim_top.sv @@
// Channel   Dir  Payload
// s_axis    in   tdata: req_type[2:0], session_num[8:3], now_time[72:9]
// m_axis    out  tdata: status[1:0], slot_valid[2], slot_num[6:3], reclaimed_count[11:7]
// apb       in   idle_timeout at address 0
// Open, release, destroy and acquire with a free slot: run in S_EXEC, result in S_OUT.
// Reclaim scans every slot in turn (table read, then check) before its result;
// acquire on an empty list runs that scan, then a table lookup, then S_EXEC.
// Reset is synchronous; all slots free after it, then a clearing pass over the session
// table before the first request reaches the sequencer. A stalled result holds the
// sequencer; the two-entry queue keeps taking requests until it is full.
// Depends on rpa_pkg, rpa_front, rpa_req_queue, rpa_back.
`timescale 1ns / 1ps
module resource_pool_allocator_idle_reclaim_top #(
    parameter int POOL_SLOTS   = rpa_pkg::POOL_SLOTS,
    parameter int MAX_SESSIONS = rpa_pkg::MAX_SESSIONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // req_type, session_num, now_time
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status, slot_valid, slot_num, reclaimed_count
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] timeout_reg;
    rpa_pkg::req_t fr_req, q_req;
    logic q_valid, q_ready;
    logic [1:0] st;
    logic sv;
    logic [3:0] sn;
    logic [4:0] rc;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? timeout_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= rpa_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            timeout_reg <= pwdata;
        end
    end

    rpa_front u_front (
        .req_type   (s_axis_tdata[2:0]),
        .session_num(s_axis_tdata[8:3]),
        .now_time   (s_axis_tdata[72:9]),
        .req        (fr_req)
    );

    rpa_req_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(s_axis_tvalid), .wr_ready(s_axis_tready), .wr_data(fr_req),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
    );

    rpa_back #(.POOL_SLOTS(POOL_SLOTS), .MAX_SESSIONS(MAX_SESSIONS)) u_back (
        .aclk, .aresetn,
        .idle_timeout(timeout_reg),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
        .res_status(st), .res_slot_valid(sv), .res_slot_num(sn), .res_reclaimed(rc)
    );

    assign m_axis_tdata = {4'd0, rc, sn, sv, st};
endmodule

@@ rtl/rpa_checker.sv @@
// Port-level checker for the slot pool allocator, bound to the top level.
// Depends on resource_pool_allocator_idle_reclaim_top_assert.svh.
`timescale 1ns / 1ps
`include "resource_pool_allocator_idle_reclaim_top_assert.svh"
module rpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `RPA_ASSERT_IMP(a_grant_ok, aclk, aresetn, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1:0] == 2'd0)
    `RPA_ASSERT_IMP(a_slot_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[6:3] == 4'd0)
    `RPA_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[15:12] == 4'd0)
    `RPA_ASSERT_NXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind resource_pool_allocator_idle_reclaim_top rpa_checker u_rpa_checker (
    .aclk(aclk), .aresetn(aresetn), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
